/* src/gscw_pkg.sv */
// Shared types, constants and control structures for the grid segment cell walk.
`default_nettype none
package gscw_pkg;

  localparam int MAX_STEPS = 64;
  localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam int COORD_W = 20;
  localparam int SPAN_W  = 20;
  localparam int NUM_W   = 16;   // 256 + MAX_STEPS * 256 fits
  localparam int SEED_W  = 9;    // first numerator is at most 256
  localparam int PROD_W  = SEED_W + SPAN_W;
  localparam int ERR_W   = 37;   // signed difference of the two cross products
  localparam int FRAC_W  = 8;

  localparam logic [NUM_W-1:0] UNIT = NUM_W'(256);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SPAN_W-1:0]         span_t;
  typedef logic [NUM_W-1:0]          num_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic [STEP_W-1:0]         step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_DIFF,
    S_WALK
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load;
    logic mul_x;
    logic mul_y;
    logic diff;
    logic walk;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic done;
  } stat_t;

endpackage
`default_nettype wire

/* src/gscw_axis.sv */
// One axis: step sign, span, crossing numerator and current coordinate.
`default_nettype none
module gscw_axis (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire logic            step,
  input  wire gscw_pkg::coord_t b,
  input  wire gscw_pkg::coord_t e,
  output gscw_pkg::coord_t     coord,
  output gscw_pkg::span_t      span,
  output gscw_pkg::num_t       num,
  output logic                 fin,
  output logic                 reached_now,
  output logic                 reached_adv
);
  import gscw_pkg::*;

  logic                 neg;
  logic signed [COORD_W:0] d;
  logic [COORD_W:0]     mag;
  logic                 d_zero;
  logic                 d_pos;
  num_t                 frac;
  num_t                 num0;
  logic [SPAN_W:0]      num_now_w;
  logic [SPAN_W:0]      num_adv_w;

  assign d      = {e[COORD_W-1], e} - {b[COORD_W-1], b};
  assign d_zero = (d == '0);
  assign d_pos  = !d[COORD_W] && !d_zero;
  assign mag    = d[COORD_W] ? (~d + 1'b1) : d;
  assign frac   = NUM_W'(b[FRAC_W-1:0]);
  // negative direction: first crossing sits at the fraction itself
  assign num0   = d_pos ? (UNIT - frac) : (d_zero ? '0 : frac);

  always_ff @(posedge clk) begin
    if (load) begin
      coord <= b;
      span  <= mag[SPAN_W-1:0];
      num   <= num0;
      fin   <= !d_zero;
      neg   <= d[COORD_W];
    end else if (step) begin
      num <= num + UNIT;
      if (fin) begin
        coord <= neg ? coord - COORD_W'(UNIT) : coord + COORD_W'(UNIT);
      end
    end
  end

  assign num_now_w   = (SPAN_W+1)'(num);
  assign num_adv_w   = (SPAN_W+1)'(num) + (SPAN_W+1)'(UNIT);
  assign reached_now = num_now_w >= {1'b0, span};
  assign reached_adv = num_adv_w >= {1'b0, span};

endmodule
`default_nettype wire

/* src/gscw_err_unit.sv */
// Shared multiplier and adder holding the cross-product difference nx*sy - ny*sx.
`default_nettype none
module gscw_err_unit (
  input  wire logic            clk,
  input  wire gscw_pkg::ctrl_t ctl,
  input  wire logic            x_first,
  input  wire gscw_pkg::num_t  num_x,
  input  wire gscw_pkg::num_t  num_y,
  input  wire gscw_pkg::span_t span_x,
  input  wire gscw_pkg::span_t span_y,
  output logic                 err_neg
);
  import gscw_pkg::*;

  prod_t               prod;
  err_t                err;
  logic [SEED_W-1:0]   mul_a;
  span_t               mul_b;
  err_t                addend;
  logic                sub;
  err_t                err_next;

  assign mul_a = ctl.mul_y ? num_y[SEED_W-1:0] : num_x[SEED_W-1:0];
  assign mul_b = ctl.mul_y ? span_x : span_y;

  always_comb begin
    addend = '0;
    sub    = 1'b0;
    if (ctl.mul_y) begin
      addend = ERR_W'(prod);
    end else if (ctl.diff) begin
      addend = ERR_W'(prod);
      sub    = 1'b1;
    end else if (ctl.walk) begin
      if (x_first) begin
        addend = ERR_W'({span_y, 8'b0});
      end else begin
        addend = ERR_W'({span_x, 8'b0});
        sub    = 1'b1;
      end
    end
  end

  assign err_next = err + (addend ^ {ERR_W{sub}}) + ERR_W'(sub);

  always_ff @(posedge clk) begin
    if (ctl.mul_x || ctl.mul_y) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.load) begin
      err <= '0;
    end else if (ctl.mul_y || ctl.diff || ctl.walk) begin
      err <= err_next;
    end
  end

  assign err_neg = err[ERR_W-1];

endmodule
`default_nettype wire

/* src/gscw_ctrl.sv */
// Sequencer: setup multiplies, then one walk step per cycle with a step count.
`default_nettype none
module gscw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire gscw_pkg::stat_t stat,
  output gscw_pkg::ctrl_t      ctl,
  output logic                 busy,
  output logic                 walk_end,
  output logic                 walk_trunc
);
  import gscw_pkg::*;

  state_t state;
  state_t state_next;
  step_t  k;
  logic   at_limit;

  assign at_limit = (k == STEP_W'(MAX_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      k <= '0;
    end else if (ctl.walk) begin
      k <= k + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    walk_end   = 1'b0;
    walk_trunc = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        ctl.mul_x  = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        ctl.mul_y  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        ctl.diff   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        ctl.walk   = 1'b1;
        walk_end   = stat.done || at_limit;
        walk_trunc = !stat.done && at_limit;
        if (walk_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/grid_segment_cell_walk.sv */
// Top level of the grid segment cell walk.
//
// Walks the unit grid cells crossed by a segment in signed Q12.8 and gives
// one point per step along the axis whose next crossing comes first.
//
// Input channel: begin_x/begin_y/end_x/end_y are taken when start is high
// and busy is low; busy stays high until the last point has been produced.
// Output channel: each point shows on cell_x/cell_y for one cycle with
// strobe high; last_cell marks the final point and truncated marks a walk
// cut short at MAX_STEPS. The receiver has no way to stall, so every
// strobe cycle is a completed transfer.
//
// Timing: the accepting edge loads the axes, then the setup states S_MUL_X,
// S_MUL_Y and S_DIFF run on the shared multiplier and adder (two seed
// products, then their difference), then one walk step per cycle through
// that same adder. Each walk step registers one point, shown with strobe;
// the points follow every cycle up to the final one. A new segment may be
// started in the cycle that shows the final point.
//
// Reset: synchronous rst returns the sequencer to idle and clears strobe.
`default_nettype none
module grid_segment_cell_walk (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire gscw_pkg::coord_t begin_x,
  input  wire gscw_pkg::coord_t begin_y,
  input  wire gscw_pkg::coord_t end_x,
  input  wire gscw_pkg::coord_t end_y,
  output logic                 strobe,
  output gscw_pkg::coord_t     cell_x,
  output gscw_pkg::coord_t     cell_y,
  output logic                 last_cell,
  output logic                 truncated
);
  import gscw_pkg::*;

  ctrl_t ctl;
  stat_t stat;
  logic  walk_end;
  logic  walk_trunc;
  logic  err_neg;
  logic  x_first;

  span_t span_x, span_y;
  num_t  num_x, num_y;
  logic  fin_x, fin_y;
  logic  now_x, now_y, adv_x, adv_y;

  // x wins only on a strictly earlier crossing; ties and double infinity go to y
  assign x_first = fin_x && (!fin_y || err_neg);

  // walk is over once both crossing parameters have reached one
  assign stat.done = (!fin_x || (x_first ? adv_x : now_x)) &&
                     (!fin_y || (x_first ? now_y : adv_y));

  gscw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy),
    .walk_end   (walk_end),
    .walk_trunc (walk_trunc)
  );

  gscw_axis u_axis_x (
    .clk         (clk),
    .load        (ctl.load),
    .step        (ctl.walk && x_first),
    .b           (begin_x),
    .e           (end_x),
    .coord       (cell_x),
    .span        (span_x),
    .num         (num_x),
    .fin         (fin_x),
    .reached_now (now_x),
    .reached_adv (adv_x)
  );

  gscw_axis u_axis_y (
    .clk         (clk),
    .load        (ctl.load),
    .step        (ctl.walk && !x_first),
    .b           (begin_y),
    .e           (end_y),
    .coord       (cell_y),
    .span        (span_y),
    .num         (num_y),
    .fin         (fin_y),
    .reached_now (now_y),
    .reached_adv (adv_y)
  );

  gscw_err_unit u_err (
    .clk     (clk),
    .ctl     (ctl),
    .x_first (x_first),
    .num_x   (num_x),
    .num_y   (num_y),
    .span_x  (span_x),
    .span_y  (span_y),
    .err_neg (err_neg)
  );

  // The axis coordinate registers double as the result registers: they hold
  // the stepped point through the strobe cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      last_cell <= 1'b0;
      truncated <= 1'b0;
    end else begin
      strobe    <= ctl.walk;
      last_cell <= walk_end;
      truncated <= walk_trunc;
    end
  end

endmodule
`default_nettype wire

/* src/gscw_checker.sv */
// Port-level checks for the grid segment cell walk, bound to the top level.
`default_nettype none
module gscw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic strobe,
  input wire logic last_cell,
  input wire logic truncated
);

  // an accepted segment always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("segment accepted but busy not raised");

  // a point only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("point transfer without a walk in progress");

  // points of one segment come back to back until the final one
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_cell |=> strobe)
    else $error("gap inside a walk");

  // the final point frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_cell |-> !busy)
    else $error("busy still high on the final point");

  // truncation only marks a final point
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    truncated |-> strobe && last_cell)
    else $error("truncated without final point");

endmodule

bind grid_segment_cell_walk gscw_checker u_gscw_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .last_cell (last_cell),
  .truncated (truncated)
);
`default_nettype wire
